// ===== src/lps_pkg.sv =====
// ----------------------------------------------------------------------------
// lps_pkg: shared types and constants for the line pixel stepper
// Coordinate width, queue sizing, direction and opcode codes, and the
// queue entry that carries a classified item from the front to the back.
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int COORD_BITS  = 12;  // internal coordinate width, 8 to 16
  localparam int FIELD_BITS  = 12;  // width of coordinate ports
  localparam int COLOR_BITS  = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 16;

  typedef logic [FIELD_BITS-1:0] field_t;
  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS:0]   err_t;
  typedef logic [COORD_BITS:0]   cnt_t;
  typedef logic [COLOR_BITS-1:0] color_t;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_PLUS  = 2'd1,
    DIR_MINUS = 2'd3
  } dir_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MIRROR = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_COLOR  = 2'd2
  } cfg_idx_t;

  localparam field_t WIDTH_RESET = field_t'(320);

  typedef struct packed {
    logic   is_start;
    dir_t   dir_x;
    dir_t   dir_y;
    coord_t start_col;
    coord_t start_row;
    coord_t abs_dx;
    coord_t abs_dy;
    coord_t major;
  } qentry_t;

  typedef struct packed {
    logic   mirror;
    field_t panel_width;
    color_t pen_color;
  } cfg_t;

  // Zero-extend or truncate a port field to the coordinate width.
  function automatic coord_t to_coord(field_t v);
    logic [COORD_BITS+FIELD_BITS-1:0] wide;
    wide = {{COORD_BITS{1'b0}}, v};
    return wide[COORD_BITS-1:0];
  endfunction

  // Zero-extend or truncate a coordinate to the port width.
  function automatic field_t to_field(coord_t c);
    logic [COORD_BITS+FIELD_BITS-1:0] wide;
    wide = {{FIELD_BITS{1'b0}}, c};
    return wide[FIELD_BITS-1:0];
  endfunction

endpackage

// ===== src/lps_front.sv =====
// ----------------------------------------------------------------------------
// lps_front: item intake and classification
// Decodes the opcode and, for a start item, works out step directions,
// absolute deltas and the major distance before the item is queued.
// ----------------------------------------------------------------------------
module lps_front (
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_op,
  input  lps_pkg::field_t in_start_x,
  input  lps_pkg::field_t in_start_y,
  input  lps_pkg::field_t in_end_x,
  input  lps_pkg::field_t in_end_y,
  input  logic            q_ready,
  output logic            q_push,
  output lps_pkg::qentry_t q_entry
);
  import lps_pkg::*;

  coord_t sx, sy, ex, ey;
  coord_t adx, ady;
  dir_t   dx_dir, dy_dir;

  assign sx = to_coord(in_start_x);
  assign sy = to_coord(in_start_y);
  assign ex = to_coord(in_end_x);
  assign ey = to_coord(in_end_y);

  always_comb begin
    adx = (ex >= sx) ? coord_t'(ex - sx) : coord_t'(sx - ex);
    ady = (ey >= sy) ? coord_t'(ey - sy) : coord_t'(sy - ey);
    if (ex > sx) begin
      dx_dir = DIR_PLUS;
    end else if (ex < sx) begin
      dx_dir = DIR_MINUS;
    end else begin
      dx_dir = DIR_NONE;
    end
    if (ey > sy) begin
      dy_dir = DIR_PLUS;
    end else if (ey < sy) begin
      dy_dir = DIR_MINUS;
    end else begin
      dy_dir = DIR_NONE;
    end
  end

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;

  always_comb begin
    q_entry.is_start  = (op_t'(in_op) == OP_START);
    q_entry.dir_x     = dx_dir;
    q_entry.dir_y     = dy_dir;
    q_entry.start_col = sx;
    q_entry.start_row = sy;
    q_entry.abs_dx    = adx;
    q_entry.abs_dy    = ady;
    q_entry.major     = (adx > ady) ? adx : ady;
  end

endmodule

// ===== src/lps_queue.sv =====
// ----------------------------------------------------------------------------
// lps_queue: short item queue between front and back
// Circular buffer of classified items; push when not full, pop from head.
// ----------------------------------------------------------------------------
module lps_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lps_pkg::qentry_t push_entry,
  output logic             push_ready,
  input  logic             pop,
  output logic             head_valid,
  output lps_pkg::qentry_t head_entry
);
  import lps_pkg::*;

  qentry_t                mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0]   count_r, count_nxt;
  logic                   do_pop;

  localparam logic [QPTR_BITS-1:0] PTR_LAST = QPTR_BITS'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_BITS-1:0] CNT_FULL = QCNT_BITS'(QUEUE_DEPTH);

  assign push_ready = (count_r != CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_entry = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== src/lps_back.sv =====
// ----------------------------------------------------------------------------
// lps_back: line stepper and pixel output register
// Loads a line on a start item; on each step item of an active line emits
// one pixel and advances the two error accumulators and the current position.
// ----------------------------------------------------------------------------
module lps_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  lps_pkg::qentry_t head_entry,
  output logic             pop,
  input  lps_pkg::cfg_t    cfg,
  output logic             out_valid,
  input  logic             out_ready,
  output lps_pkg::field_t  out_pixel_col,
  output lps_pkg::field_t  out_pixel_row,
  output lps_pkg::color_t  out_pixel_color,
  output logic             out_last_pixel
);
  import lps_pkg::*;

  function automatic coord_t move_axis(coord_t pos, dir_t dir);
    case (dir)
      DIR_PLUS:  return coord_t'(pos + 1'b1);
      DIR_MINUS: return coord_t'(pos - 1'b1);
      default:   return pos;
    endcase
  endfunction

  coord_t cur_col_r, cur_col_nxt;
  coord_t cur_row_r, cur_row_nxt;
  coord_t abs_dx_r, abs_dx_nxt;
  coord_t abs_dy_r, abs_dy_nxt;
  coord_t major_r, major_nxt;
  dir_t   dir_x_r, dir_x_nxt;
  dir_t   dir_y_r, dir_y_nxt;
  err_t   err_x_r, err_x_nxt;
  err_t   err_y_r, err_y_nxt;
  cnt_t   count_r, count_nxt;
  logic   busy_r, busy_nxt;

  logic   out_valid_r, out_valid_nxt;
  field_t col_r, col_nxt;
  field_t row_r, row_nxt;
  color_t color_r, color_nxt;
  logic   last_r, last_nxt;

  logic   out_free, do_step, is_last, x_move, y_move;
  err_t   err_x_sum, err_y_sum;
  coord_t out_col;

  assign out_free  = !out_valid_r || out_ready;
  assign pop       = head_valid && (head_entry.is_start || !busy_r || out_free);
  assign do_step   = head_valid && !head_entry.is_start && busy_r && out_free;

  assign err_x_sum = err_x_r + {1'b0, abs_dx_r};
  assign err_y_sum = err_y_r + {1'b0, abs_dy_r};
  assign x_move    = err_x_sum > {1'b0, major_r};
  assign y_move    = err_y_sum > {1'b0, major_r};
  assign is_last   = (count_r == cnt_t'({1'b0, major_r} + 1'b1));
  assign out_col   = cfg.mirror
                   ? coord_t'(to_coord(cfg.panel_width) - coord_t'(1) - cur_col_r)
                   : cur_col_r;

  always_comb begin
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    abs_dx_nxt    = abs_dx_r;
    abs_dy_nxt    = abs_dy_r;
    major_nxt     = major_r;
    dir_x_nxt     = dir_x_r;
    dir_y_nxt     = dir_y_r;
    err_x_nxt     = err_x_r;
    err_y_nxt     = err_y_r;
    count_nxt     = count_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r && !out_ready;
    col_nxt       = col_r;
    row_nxt       = row_r;
    color_nxt     = color_r;
    last_nxt      = last_r;

    if (head_valid && head_entry.is_start) begin
      // load a new line, dropping any line in progress
      cur_col_nxt = head_entry.start_col;
      cur_row_nxt = head_entry.start_row;
      abs_dx_nxt  = head_entry.abs_dx;
      abs_dy_nxt  = head_entry.abs_dy;
      major_nxt   = head_entry.major;
      dir_x_nxt   = head_entry.dir_x;
      dir_y_nxt   = head_entry.dir_y;
      err_x_nxt   = '0;
      err_y_nxt   = '0;
      count_nxt   = '0;
      busy_nxt    = 1'b1;
    end else if (do_step) begin
      out_valid_nxt = 1'b1;
      col_nxt       = to_field(out_col);
      row_nxt       = to_field(cur_row_r);
      color_nxt     = cfg.pen_color;
      last_nxt      = is_last;
      err_x_nxt     = x_move ? err_t'(err_x_sum - {1'b0, major_r}) : err_x_sum;
      err_y_nxt     = y_move ? err_t'(err_y_sum - {1'b0, major_r}) : err_y_sum;
      if (x_move) begin
        cur_col_nxt = move_axis(cur_col_r, dir_x_r);
      end
      if (y_move) begin
        cur_row_nxt = move_axis(cur_row_r, dir_y_r);
      end
      count_nxt = count_r + 1'b1;
      if (is_last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_col_r <= cur_col_nxt;
    cur_row_r <= cur_row_nxt;
    abs_dx_r  <= abs_dx_nxt;
    abs_dy_r  <= abs_dy_nxt;
    major_r   <= major_nxt;
    dir_x_r   <= dir_x_nxt;
    dir_y_r   <= dir_y_nxt;
    err_x_r   <= err_x_nxt;
    err_y_r   <= err_y_nxt;
    count_r   <= count_nxt;
    col_r     <= col_nxt;
    row_r     <= row_nxt;
    color_r   <= color_nxt;
    last_r    <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_col   = col_r;
  assign out_pixel_row   = row_r;
  assign out_pixel_color = color_r;
  assign out_last_pixel  = last_r;

endmodule

// ===== src/line_pixel_stepper_top.sv =====
// ----------------------------------------------------------------------------
// line_pixel_stepper_top: error-accumulator line rasterizer
// Turns start and step items into panel pixel addresses with pen color.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): a transfer with in_op = start loads the two
//   endpoints and produces no pixel; a transfer with in_op = step produces
//   one pixel while a line is active and nothing otherwise. A line gives
//   max(|dx|,|dy|) + 2 pixels, the final one flagged by out_last_pixel.
//   Output channel (out_*): one pixel per transfer, held in an output
//   register until taken.
//   Config channel (cfg_*): always ready; index 0 mirror enable, 1 panel
//   width, 2 pen color. Write only while no line work is pending.
// Timing:
//   An accepted step is written into the item queue, waits at its head and
//   is then loaded into the output register, from which it shows on out_*.
//   Throughput is one item per cycle while the receiver takes every pixel,
//   set by the registered error update in the back stepper. When the receiver
//   stalls, the output register holds, the two-entry queue fills and
//   in_ready drops; it rises again in the cycle after the receiver takes
//   a pixel.
// Reset (rst_n low, synchronous): queue emptied, no line active,
//   out_valid low, mirroring off, width 320, pen color 0.
// ----------------------------------------------------------------------------
module line_pixel_stepper_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // item input
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_op,
  input  lps_pkg::field_t                   in_start_x,
  input  lps_pkg::field_t                   in_start_y,
  input  lps_pkg::field_t                   in_end_x,
  input  lps_pkg::field_t                   in_end_y,
  // pixel output
  output logic                              out_valid,
  input  logic                              out_ready,
  output lps_pkg::field_t                   out_pixel_col,
  output lps_pkg::field_t                   out_pixel_row,
  output lps_pkg::color_t                   out_pixel_color,
  output logic                              out_last_pixel,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lps_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [lps_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import lps_pkg::*;

  // configuration registers
  logic   mirror_r, mirror_nxt;
  field_t width_r, width_nxt;
  color_t color_r, color_nxt;
  cfg_t   cfg;

  // front to queue, queue to back
  logic    q_push, q_ready, q_pop, q_head_valid;
  qentry_t q_entry, q_head;

  assign cfg_ready = 1'b1;

  // decode a config transfer; unknown indexes are dropped
  always_comb begin
    mirror_nxt = mirror_r;
    width_nxt  = width_r;
    color_nxt  = color_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MIRROR: mirror_nxt = cfg_data[0];
        CFG_WIDTH:  width_nxt  = cfg_data[FIELD_BITS-1:0];
        CFG_COLOR:  color_nxt  = cfg_data[COLOR_BITS-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirror_r <= 1'b0;
      width_r  <= WIDTH_RESET;
      color_r  <= '0;
    end else begin
      mirror_r <= mirror_nxt;
      width_r  <= width_nxt;
      color_r  <= color_nxt;
    end
  end

  assign cfg.mirror      = mirror_r;
  assign cfg.panel_width = width_r;
  assign cfg.pen_color   = color_r;

  // classify and precompute start items
  lps_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op      (in_op),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .q_ready    (q_ready),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  // decouple intake from the stepper
  lps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .push_ready (q_ready),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_entry (q_head)
  );

  // step the line and drive the pixel register
  lps_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (q_head_valid),
    .head_entry      (q_head),
    .pop             (q_pop),
    .cfg             (cfg),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_col   (out_pixel_col),
    .out_pixel_row   (out_pixel_row),
    .out_pixel_color (out_pixel_color),
    .out_last_pixel  (out_last_pixel)
  );

endmodule

// ===== src/lps_checker.sv =====
// ----------------------------------------------------------------------------
// lps_checker: port-level checks for the line pixel stepper
// Watches the top-level channels over time and reports violations.
// ----------------------------------------------------------------------------
module lps_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input lps_pkg::field_t       out_pixel_col,
  input lps_pkg::field_t       out_pixel_row,
  input lps_pkg::color_t       out_pixel_color,
  input logic                  out_last_pixel
);
  import lps_pkg::*;

  // a stalled pixel holds its place and value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_col)
      && $stable(out_pixel_row) && $stable(out_pixel_color)
      && $stable(out_last_pixel))
    else $error("stalled pixel changed");

  // reset leaves no pixel pending and the intake open
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  // a line end is never followed directly by another line end
  a_last_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_pixel |=> !(out_valid && out_last_pixel))
    else $error("two last pixels in a row");

endmodule

bind line_pixel_stepper_top lps_checker u_lps_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_pixel_col   (out_pixel_col),
  .out_pixel_row   (out_pixel_row),
  .out_pixel_color (out_pixel_color),
  .out_last_pixel  (out_last_pixel)
);
